@@ design/quaternion_to_euler_angles_macros.svh @@
// Assertion macros for the checker file.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define Q2E_ASSERT(label, ck, rstn, cond, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (cond)) else $error(msg);

// Property whose consequent holds in the cycle after the antecedent.
`define Q2E_ASSERT_NEXT(label, ck, rstn, pre, post, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

@@ design/q2e_pkg.sv @@
// Types, constants and helper functions for the quaternion to Euler block.
package q2e_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int QIN_W = 24;
	localparam int EPS_W = 23;
	localparam int OUT_W = 25;
	localparam int PROD_W = 48;
	localparam int WIDE_W = 51;
	localparam int ARG_W = 32;
	localparam int ANG_W = 34;
	localparam int RAD_W = 61;
	localparam int SQ_N = 31;
	localparam int SQ_REM_W = 34;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;

	localparam logic [EPS_W-1:0] EPS_RESET = 23'd8;
	localparam logic signed [WIDE_W-1:0] ONE_Q44 = 51'sh1000_0000_0000;
	localparam logic signed [WIDE_W-1:0] HALF_Q44 = 51'sh0800_0000_0000;
	localparam logic signed [WIDE_W-1:0] ROUND_Q14 = 51'sd8192;
	localparam logic [RAD_W-1:0] ONE_Q60 = 61'h1000_0000_0000_0000;
	localparam logic signed [QIN_W-1:0] ONE_Q22 = 24'sd4194304;
	localparam logic signed [ANG_W-1:0] QUARTER_Q24 = 34'sd1509949440;
	localparam logic signed [ANG_W-1:0] ROUND_Q8 = 34'sd128;
	localparam logic signed [OUT_W-1:0] ANGLE_P90 = 25'sd5898240;
	localparam logic signed [OUT_W-1:0] ANGLE_M90 = -25'sd5898240;

	// atan(2^-i) in degrees, Q.24
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
		32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
		32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
		32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef enum logic [1:0] {
		GC_NORMAL = 2'd0,
		GC_POS90  = 2'd1,
		GC_NEG90  = 2'd2
	} gcase_t;

	// one job for the CORDIC lanes: (y, x) argument pairs in Q.30
	typedef struct packed {
		gcase_t gcase;
		logic signed [ARG_W-1:0] xa_y;
		logic signed [ARG_W-1:0] xa_x;
		logic signed [ARG_W-1:0] ya_y;
		logic signed [ARG_W-1:0] ya_x;
		logic signed [ARG_W-1:0] za_y;
		logic signed [ARG_W-1:0] za_x;
	} q2e_job_t;

	// clamp to [-1,1] in Q.44, round half up to Q.30
	function automatic logic signed [ARG_W-1:0] q44_to_q30(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] c;
		if (v > ONE_Q44) begin
			c = ONE_Q44;
		end else if (v < -ONE_Q44) begin
			c = -ONE_Q44;
		end else begin
			c = v;
		end
		c = c + ROUND_Q14;
		return $signed(c[ARG_W+13:14]);
	endfunction

	// clamp to [-1,1] in Q2.22, shift up to Q.30
	function automatic logic signed [ARG_W-1:0] q22_to_q30(input logic signed [QIN_W-1:0] v);
		logic signed [QIN_W-1:0] c;
		if (v > ONE_Q22) begin
			c = ONE_Q22;
		end else if (v < -ONE_Q22) begin
			c = -ONE_Q22;
		end else begin
			c = v;
		end
		return $signed({c, 8'd0});
	endfunction

endpackage

@@ design/q2e_if.sv @@
// Request channels: quaternion in, Euler angles out.
interface q2e_in_if import q2e_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [QIN_W-1:0] quat_w;
	logic signed [QIN_W-1:0] quat_x;
	logic signed [QIN_W-1:0] quat_y;
	logic signed [QIN_W-1:0] quat_z;

	modport source (output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, input ready);
	modport sink (input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, output ready);
endinterface

interface q2e_out_if import q2e_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [OUT_W-1:0] angle_x;
	logic signed [OUT_W-1:0] angle_y;
	logic signed [OUT_W-1:0] angle_z;
	logic [1:0] gimbal_case;

	modport source (output valid, output angle_x, output angle_y, output angle_z,
		output gimbal_case, input ready);
	modport sink (input valid, input angle_x, input angle_y, input angle_z,
		input gimbal_case, output ready);
endinterface

@@ design/q2e_front.sv @@
// Front end: products, lock classification, argument scaling and square root.
module q2e_front import q2e_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [EPS_W-1:0] eps,
	q2e_in_if.sink quat_in,
	input logic q_full,
	output logic push,
	output q2e_job_t job
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0] yz_s1, xw_s1, xz_s1, yw_s1, xy_s1, zw_s1, xx_s1, yy_s1, zz_s1;
	logic signed [QIN_W-1:0] w_s1, y_s1, z_s1, w_s2, y_s2, z_s2;
	logic signed [WIDE_W-1:0] t_s2, ny_s2, dy_s2, nz_s2, dz_s2;
	logic signed [WIDE_W-1:0] lim;
	logic lock_pos, lock_neg;
	q2e_job_t job_n, job_s3, job_s4;
	logic signed [2*ARG_W-1:0] sq_full;
	logic [RAD_W-1:0] sq_s4;

	// square-root pipeline, index SQ_N holds the finished root
	logic [SQ_N:0] sv_q;
	logic [SQ_REM_W-1:0] rem_q [SQ_N+1];
	logic [SQ_N-1:0] root_q [SQ_N+1];
	logic [2*SQ_N-1:0] nval_q [SQ_N+1];
	q2e_job_t sjob_q [SQ_N+1];
	logic [SQ_REM_W-1:0] cur [SQ_N];
	logic [SQ_REM_W-1:0] trial [SQ_N];
	logic [SQ_REM_W-1:0] nrem [SQ_N];
	logic [SQ_N-1:0] nroot [SQ_N];

	assign en = !(sv_q[SQ_N] && q_full);
	assign push = sv_q[SQ_N] && !q_full;
	assign quat_in.ready = en;

	always_comb begin
		job = sjob_q[SQ_N];
		job.xa_x = $signed({1'b0, root_q[SQ_N]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			sv_q <= '0;
		end else if (en) begin
			v_s1 <= quat_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			sv_q <= {sv_q[SQ_N-1:0], v_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yz_s1 <= quat_in.quat_y * quat_in.quat_z;
			xw_s1 <= quat_in.quat_x * quat_in.quat_w;
			xz_s1 <= quat_in.quat_x * quat_in.quat_z;
			yw_s1 <= quat_in.quat_y * quat_in.quat_w;
			xy_s1 <= quat_in.quat_x * quat_in.quat_y;
			zw_s1 <= quat_in.quat_z * quat_in.quat_w;
			xx_s1 <= quat_in.quat_x * quat_in.quat_x;
			yy_s1 <= quat_in.quat_y * quat_in.quat_y;
			zz_s1 <= quat_in.quat_z * quat_in.quat_z;
			w_s1 <= quat_in.quat_w;
			y_s1 <= quat_in.quat_y;
			z_s1 <= quat_in.quat_z;

			t_s2 <= (WIDE_W'(yz_s1) - WIDE_W'(xw_s1)) <<< 1;
			ny_s2 <= WIDE_W'(xz_s1) + WIDE_W'(yw_s1);
			dy_s2 <= HALF_Q44 - WIDE_W'(xx_s1) - WIDE_W'(yy_s1);
			nz_s2 <= WIDE_W'(xy_s1) + WIDE_W'(zw_s1);
			dz_s2 <= HALF_Q44 - WIDE_W'(xx_s1) - WIDE_W'(zz_s1);
			w_s2 <= w_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;

			job_s3 <= job_n;

			job_s4 <= job_s3;
			sq_s4 <= sq_full[RAD_W-1:0];

			rem_q[0] <= '0;
			root_q[0] <= '0;
			nval_q[0] <= {1'b0, ONE_Q60 - sq_s4};
			sjob_q[0] <= job_s4;
			for (int k = 0; k < SQ_N; k++) begin
				rem_q[k+1] <= nrem[k];
				root_q[k+1] <= nroot[k];
				nval_q[k+1] <= nval_q[k];
				sjob_q[k+1] <= sjob_q[k];
			end
		end
	end

	// lock test is exact in Q.44; +90 wins when both hold
	always_comb begin
		lim = ONE_Q44 - $signed({6'd0, eps, 22'd0});
		lock_pos = t_s2 >= lim;
		lock_neg = -t_s2 >= lim;
		job_n.xa_x = '0;
		if (lock_pos || lock_neg) begin
			job_n.gcase = lock_pos ? GC_POS90 : GC_NEG90;
			job_n.xa_y = '0;
			job_n.ya_y = q22_to_q30(y_s2);
			job_n.ya_x = q22_to_q30(w_s2);
			job_n.za_y = q22_to_q30(z_s2);
			job_n.za_x = q22_to_q30(w_s2);
		end else begin
			job_n.gcase = GC_NORMAL;
			job_n.xa_y = q44_to_q30(t_s2);
			job_n.ya_y = q44_to_q30(ny_s2);
			job_n.ya_x = q44_to_q30(dy_s2);
			job_n.za_y = q44_to_q30(nz_s2);
			job_n.za_x = q44_to_q30(dz_s2);
		end
	end

	assign sq_full = $signed(job_s3.xa_y) * $signed(job_s3.xa_y);

	// restoring square root, one result bit per stage
	always_comb begin
		for (int k = 0; k < SQ_N; k++) begin
			cur[k] = {rem_q[k][SQ_REM_W-3:0], nval_q[k][2*(SQ_N-1-k)+1 -: 2]};
			trial[k] = {1'b0, root_q[k], 2'b01};
			if (cur[k] >= trial[k]) begin
				nrem[k] = cur[k] - trial[k];
				nroot[k] = {root_q[k][SQ_N-2:0], 1'b1};
			end else begin
				nrem[k] = cur[k];
				nroot[k] = {root_q[k][SQ_N-2:0], 1'b0};
			end
		end
	end

endmodule

@@ design/q2e_queue.sv @@
// Short request queue between the front end and the CORDIC back end.
module q2e_queue import q2e_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input q2e_job_t wdata,
	input logic pop,
	output q2e_job_t rdata,
	output logic full,
	output logic not_empty
);

	q2e_job_t ent_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0] cnt_q;

	assign full = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wdata;
	end

endmodule

@@ design/q2e_cordic.sv @@
// One pipelined vectoring CORDIC lane: atan2(y, x) in Q.24 degrees.
module q2e_cordic import q2e_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic en,
	input logic signed [ARG_W-1:0] yv,
	input logic signed [ARG_W-1:0] xv,
	output logic signed [ANG_W-1:0] ang
);

	logic signed [ANG_W-1:0] cx_q [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] cy_q [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] ca_q [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0] zero_q;
	logic signed [ANG_W-1:0] nx [CORDIC_STEPS];
	logic signed [ANG_W-1:0] ny [CORDIC_STEPS];
	logic signed [ANG_W-1:0] na [CORDIC_STEPS];
	logic signed [ANG_W-1:0] xe, ye, px, py, pa;

	// left half plane: rotate by a quarter turn first
	always_comb begin
		xe = ANG_W'(xv);
		ye = ANG_W'(yv);
		if (xe < 0) begin
			if (ye >= 0) begin
				px = ye;
				py = -xe;
				pa = QUARTER_Q24;
			end else begin
				px = -ye;
				py = xe;
				pa = -QUARTER_Q24;
			end
		end else begin
			px = xe;
			py = ye;
			pa = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (cy_q[i] >= 0) begin
				nx[i] = cx_q[i] + (cy_q[i] >>> i);
				ny[i] = cy_q[i] - (cx_q[i] >>> i);
				na[i] = ca_q[i] + $signed({2'b00, ATAN_TAB[i[4:0]]});
			end else begin
				nx[i] = cx_q[i] - (cy_q[i] >>> i);
				ny[i] = cy_q[i] + (cx_q[i] >>> i);
				na[i] = ca_q[i] - $signed({2'b00, ATAN_TAB[i[4:0]]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q[0] <= px;
			cy_q[0] <= py;
			ca_q[0] <= pa;
			zero_q[0] <= (xv == '0) && (yv == '0);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				cx_q[i+1] <= nx[i];
				cy_q[i+1] <= ny[i];
				ca_q[i+1] <= na[i];
				zero_q[i+1] <= zero_q[i];
			end
		end
	end

	assign ang = zero_q[CORDIC_STEPS] ? '0 : ca_q[CORDIC_STEPS];

endmodule

@@ design/q2e_back.sv @@
// Back end: three CORDIC lanes, final rounding and the output register.
module q2e_back import q2e_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input q2e_job_t q_job,
	output logic pop,
	q2e_out_if.source euler_out
);

	localparam int LAT = CORDIC_STEPS + 1;

	logic en;
	logic [LAT-1:0] v_q;
	gcase_t gc_q [LAT];
	logic signed [ANG_W-1:0] ang_x, ang_y, ang_z;
	logic signed [ANG_W-1:0] rx, ry, rz;
	logic ov_q;
	logic signed [OUT_W-1:0] ax_q, ay_q, az_q;
	gcase_t gco_q;

	assign en = !ov_q || euler_out.ready;
	assign pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			ov_q <= 1'b0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], pop};
			ov_q <= v_q[LAT-1];
		end
	end

	q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
		.clk(clk), .en(en), .yv(q_job.xa_y), .xv(q_job.xa_x), .ang(ang_x)
	);
	q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
		.clk(clk), .en(en), .yv(q_job.ya_y), .xv(q_job.ya_x), .ang(ang_y)
	);
	q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
		.clk(clk), .en(en), .yv(q_job.za_y), .xv(q_job.za_x), .ang(ang_z)
	);

	// Q.24 to Q.16, round half up
	assign rx = ang_x + ROUND_Q8;
	assign ry = ang_y + ROUND_Q8;
	assign rz = ang_z + ROUND_Q8;

	always_ff @(posedge clk) begin
		if (en) begin
			gc_q[0] <= q_job.gcase;
			for (int k = 1; k < LAT; k++) begin
				gc_q[k] <= gc_q[k-1];
			end
			case (gc_q[LAT-1])
				GC_POS90: ax_q <= ANGLE_P90;
				GC_NEG90: ax_q <= ANGLE_M90;
				default:  ax_q <= $signed(rx[OUT_W+7:8]);
			endcase
			ay_q <= -$signed(ry[OUT_W+7:8]);
			az_q <= -$signed(rz[OUT_W+7:8]);
			gco_q <= gc_q[LAT-1];
		end
	end

	assign euler_out.valid = ov_q;
	assign euler_out.angle_x = ax_q;
	assign euler_out.angle_y = ay_q;
	assign euler_out.angle_z = az_q;
	assign euler_out.gimbal_case = gco_q;

endmodule

@@ design/quaternion_to_euler_angles.sv @@
// Top level: quaternion (Q2.22) to Euler angles (Q9.16 degrees).
//
//   channel    dir  handshake     payload
//   quat_in    in   valid/ready   quat_w, quat_x, quat_y, quat_z
//   euler_out  out  valid/ready   angle_x, angle_y, angle_z, gimbal_case
//   cfg        in   cfg_we        cfg_wdata -> gimbal_epsilon
//
// One request per clock sustained while the queue has room; a request passes the front
// products, the 32-stage square-root pipeline, the queue and the CORDIC_STEPS + 1 lane stages.
// A 4-entry queue separates front end and lanes, so each side stalls on its own.
// Reset clears all valid flags and sets gimbal_epsilon to 8; no clearing pass.
module quaternion_to_euler_angles import q2e_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [EPS_W-1:0] cfg_wdata,
	q2e_in_if.sink quat_in,
	q2e_out_if.source euler_out
);

	logic [EPS_W-1:0] eps_q;
	logic push, pop, q_full, q_valid;
	q2e_job_t f_job, q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	q2e_front u_front (
		.clk(clk), .arst_n(arst_n), .eps(eps_q), .quat_in(quat_in),
		.q_full(q_full), .push(push), .job(f_job)
	);

	q2e_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(f_job), .pop(pop),
		.rdata(q_job), .full(q_full), .not_empty(q_valid)
	);

	q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_job(q_job), .pop(pop),
		.euler_out(euler_out)
	);

endmodule

@@ design/q2e_checker.sv @@
// Port checker for the quaternion to Euler block, bound to the top level.
`include "quaternion_to_euler_angles_macros.svh"

module q2e_checker import q2e_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic signed [OUT_W-1:0] angle_x,
	input logic [1:0] gimbal_case
);

	`Q2E_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`Q2E_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(angle_x), "angle_x changed while stalled")
	`Q2E_ASSERT(a_lock_pos, clk, arst_n, !(out_valid && gimbal_case == GC_POS90) || angle_x == ANGLE_P90, "lock at +90 without +90 x angle")
	`Q2E_ASSERT(a_lock_neg, clk, arst_n, !(out_valid && gimbal_case == GC_NEG90) || angle_x == ANGLE_M90, "lock at -90 without -90 x angle")

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(euler_out.valid),
	.out_ready(euler_out.ready),
	.angle_x(euler_out.angle_x),
	.gimbal_case(euler_out.gimbal_case)
);
